@@ design/pcap_record_deframer_top_assert.svh @@
// assertion macros for the pcap record deframer checker
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef PCAP_RECORD_DEFRAMER_TOP_ASSERT_SVH
`define PCAP_RECORD_DEFRAMER_TOP_ASSERT_SVH

// consequent checked in the cycle after the trigger
`define PCAPDF_CHECK_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("pcap deframer check failed");

// consequent checked in the same cycle as the trigger
`define PCAPDF_CHECK_NOW(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error("pcap deframer check failed");

`endif

@@ design/pcapdf_pkg.sv @@
// shared types and constants for the pcap record deframer
// no dependencies
`timescale 1ns / 1ps

package pcapdf_pkg;

  // width of the running file offset counter
  localparam int unsigned OFFSET_BITS = 32;

  localparam int unsigned GLOBAL_LEN = 24;
  localparam int unsigned RECORD_LEN = 16;
  // past bytes kept: enough for global header bytes 4..22
  localparam int unsigned HIST_BYTES = 19;

  localparam logic [7:0] MAGIC_B0 = 8'hd4;
  localparam logic [7:0] MAGIC_B1 = 8'hc3;
  localparam logic [7:0] MAGIC_B2 = 8'hb2;
  localparam logic [7:0] MAGIC_B3 = 8'ha1;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_RECORD  = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_RECORDS = 2'd1;
  localparam logic [1:0] PH_IGNORE  = 2'd2;

  // tdata split: global header fields low, record fields high
  localparam int unsigned HDR_W   = 160;
  localparam int unsigned REC_W   = 160;
  localparam int unsigned TDATA_W = HDR_W + REC_W;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] version_major;
    logic [15:0] version_minor;
    logic [31:0] zone_offset;
    logic [31:0] timestamp_accuracy;
    logic [31:0] snapshot_length;
    logic [31:0] link_layer_type;
    logic [31:0] stamp_seconds;
    logic [31:0] stamp_micros;
    logic [31:0] captured_length;
    logic [31:0] original_length;
    logic [31:0] payload_offset;
  } result_t;

endpackage

@@ design/pcapdf_parser.sv @@
// byte-wise parse state and result formation for the pcap record deframer
// depends on pcapdf_pkg
`timescale 1ns / 1ps

module pcapdf_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  input  logic                final_i,
  output logic                emit_o,
  output pcapdf_pkg::result_t result_o
);

  logic [1:0]                         phase_q, phase_d;
  logic                               big_q, big_d;
  logic [4:0]                         fill_q, fill_d;
  logic [31:0]                        skip_q, skip_d;
  logic                               pending_q, pending_d;
  logic [pcapdf_pkg::OFFSET_BITS-1:0] pos_q, pos_d;
  logic [7:0]                         hist_q [pcapdf_pkg::HIST_BYTES];

  logic        store;
  logic        emit;
  logic        magic_le, magic_be;
  logic [31:0] skip_cur;
  logic [31:0] rec_cap;

  // assemble words in file order, first byte given first
  function automatic logic [15:0] w16(logic [7:0] a0, logic [7:0] a1, logic big);
    w16 = big ? {a0, a1} : {a1, a0};
  endfunction

  function automatic logic [31:0] w32(logic [7:0] a0, logic [7:0] a1,
                                      logic [7:0] a2, logic [7:0] a3, logic big);
    w32 = big ? {a0, a1, a2, a3} : {a3, a2, a1, a0};
  endfunction

  assign magic_le = (hist_q[2] == pcapdf_pkg::MAGIC_B0) && (hist_q[1] == pcapdf_pkg::MAGIC_B1)
                 && (hist_q[0] == pcapdf_pkg::MAGIC_B2) && (byte_i == pcapdf_pkg::MAGIC_B3);
  assign magic_be = (hist_q[2] == pcapdf_pkg::MAGIC_B3) && (hist_q[1] == pcapdf_pkg::MAGIC_B2)
                 && (hist_q[0] == pcapdf_pkg::MAGIC_B1) && (byte_i == pcapdf_pkg::MAGIC_B0);

  // record header bytes 0..15 sit in hist_q[15..0]
  assign rec_cap = w32(hist_q[7], hist_q[6], hist_q[5], hist_q[4], big_q);

  always_comb begin
    phase_d   = phase_q;
    big_d     = big_q;
    fill_d    = fill_q;
    skip_d    = skip_q;
    pending_d = pending_q;
    pos_d     = pos_q + 1'b1;
    store     = 1'b0;
    emit      = 1'b0;
    skip_cur  = skip_q;
    result_o  = '0;

    case (phase_q)
      pcapdf_pkg::PH_HEADER: begin
        store  = 1'b1;
        fill_d = fill_q + 5'd1;
        if (fill_q == 5'd3) begin
          if (magic_le) begin
            big_d = 1'b0;
          end else if (magic_be) begin
            big_d = 1'b1;
          end else begin
            phase_d = pcapdf_pkg::PH_IGNORE;
            emit    = 1'b1;
            result_o.result_kind = pcapdf_pkg::KIND_INVALID;
          end
        end
        if (fill_q == 5'(pcapdf_pkg::GLOBAL_LEN - 1)) begin
          // global header bytes 4..22 sit in hist_q[18..0], byte 23 is this one
          emit    = 1'b1;
          phase_d = pcapdf_pkg::PH_RECORDS;
          fill_d  = '0;
          result_o.result_kind        = pcapdf_pkg::KIND_HEADER;
          result_o.version_major      = w16(hist_q[18], hist_q[17], big_q);
          result_o.version_minor      = w16(hist_q[16], hist_q[15], big_q);
          result_o.zone_offset        = w32(hist_q[14], hist_q[13], hist_q[12],
                                            hist_q[11], big_q);
          result_o.timestamp_accuracy = w32(hist_q[10], hist_q[9], hist_q[8],
                                            hist_q[7], big_q);
          result_o.snapshot_length    = w32(hist_q[6], hist_q[5], hist_q[4],
                                            hist_q[3], big_q);
          result_o.link_layer_type    = w32(hist_q[2], hist_q[1], hist_q[0],
                                            byte_i, big_q);
        end else if (final_i) begin
          // short file, or bad magic on the final byte: a single invalid result
          emit     = 1'b1;
          result_o = '0;
          result_o.result_kind = pcapdf_pkg::KIND_INVALID;
        end
      end
      pcapdf_pkg::PH_RECORDS: begin
        if (pending_q) begin
          emit      = 1'b1;
          skip_cur  = rec_cap;
          pending_d = 1'b0;
          result_o.result_kind     = pcapdf_pkg::KIND_RECORD;
          result_o.stamp_seconds   = w32(hist_q[15], hist_q[14], hist_q[13], hist_q[12], big_q);
          result_o.stamp_micros    = w32(hist_q[11], hist_q[10], hist_q[9], hist_q[8], big_q);
          result_o.captured_length = rec_cap;
          result_o.original_length = w32(hist_q[3], hist_q[2], hist_q[1], hist_q[0], big_q);
          result_o.payload_offset  = 32'(pos_q);
        end
        if (skip_cur != '0) begin
          skip_d = skip_cur - 32'd1;
        end else begin
          // no payload left to skip, or a zero length one: this byte belongs to the next record header
          skip_d = '0;
          store  = 1'b1;
          if (fill_q == 5'(pcapdf_pkg::RECORD_LEN - 1)) begin
            fill_d    = '0;
            pending_d = 1'b1;
          end else begin
            fill_d = fill_q + 5'd1;
          end
        end
      end
      default: begin
      end
    endcase

    if (final_i) begin
      phase_d   = pcapdf_pkg::PH_HEADER;
      big_d     = 1'b0;
      fill_d    = '0;
      skip_d    = '0;
      pending_d = 1'b0;
      pos_d     = '0;
    end
  end

  assign emit_o = fire_i & emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= pcapdf_pkg::PH_HEADER;
      big_q     <= 1'b0;
      fill_q    <= '0;
      skip_q    <= '0;
      pending_q <= 1'b0;
      pos_q     <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      big_q     <= big_d;
      fill_q    <= fill_d;
      skip_q    <= skip_d;
      pending_q <= pending_d;
      pos_q     <= pos_d;
    end
  end

  // newest header byte in entry 0
  always_ff @(posedge clk_i) begin
    if (fire_i && store) begin
      hist_q[0] <= byte_i;
      for (int i = 1; i < pcapdf_pkg::HIST_BYTES; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

endmodule

@@ design/pcap_record_deframer_top.sv @@
// pcap record deframer top level: byte stream in, header and record results out
// depends on pcapdf_pkg and pcapdf_parser
//
//  channel | dir | tdata                              | side band
//  s_*     | in  | file_byte                          | tlast = final_byte
//  m_*     | out | header fields, then record fields  | tuser = result_kind
//
// one byte is taken every cycle while s_tready_o is high. a two-entry output register
// and skid stage hold results: a result enters the output register, or the skid
// entry while the output stalls. s_tready_o drops only while the skid entry is full
// (two stalled results). the parse state updates combinationally from the byte and
// is written at the accept edge. reset leaves the parser expecting the magic.
`timescale 1ns / 1ps

module pcap_record_deframer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [7:0]                     s_tdata_i,  // file_byte
  input  logic                           s_tlast_i,  // final_byte
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  // version_major, version_minor, zone_offset, timestamp_accuracy, snapshot_length,
  // link_layer_type, stamp_seconds, stamp_micros, captured_length, original_length,
  // payload_offset
  output logic [pcapdf_pkg::TDATA_W-1:0] m_tdata_o,
  output logic [1:0]                     m_tuser_o   // result_kind
);

  logic                s_fire;
  logic                emit;
  pcapdf_pkg::result_t res;
  pcapdf_pkg::result_t out_q;
  pcapdf_pkg::result_t skid_q;
  logic                out_valid_q;
  logic                skid_valid_q;
  logic                m_pop;

  assign s_tready_o = ~skid_valid_q;
  assign s_fire     = s_tvalid_i & s_tready_o;
  assign m_pop      = out_valid_q & m_tready_i;

  pcapdf_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s_fire),
    .byte_i   (s_tdata_i),
    .final_i  (s_tlast_i),
    .emit_o   (emit),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (m_pop || !out_valid_q) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= emit;
        end
      end else if (emit) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (emit) begin
        out_q <= res;
      end
    end else if (emit) begin
      skid_q <= res;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_q.result_kind;
  assign m_tdata_o  = {out_q.payload_offset, out_q.original_length, out_q.captured_length,
                       out_q.stamp_micros, out_q.stamp_seconds, out_q.link_layer_type,
                       out_q.snapshot_length, out_q.timestamp_accuracy, out_q.zone_offset,
                       out_q.version_minor, out_q.version_major};

endmodule

@@ design/pcapdf_checker.sv @@
// port-level checks for the pcap record deframer, bound to the top level
// depends on pcapdf_pkg and pcap_record_deframer_top_assert.svh
`timescale 1ns / 1ps
`include "pcap_record_deframer_top_assert.svh"

module pcapdf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_tvalid_o,
  input logic                           m_tready_i,
  input logic [pcapdf_pkg::TDATA_W-1:0] m_tdata_o,
  input logic [1:0]                     m_tuser_o
);

  // a stalled request keeps its place and payload
  `PCAPDF_CHECK_NEXT(a_valid_held, m_tvalid_o && !m_tready_i, m_tvalid_o)
  `PCAPDF_CHECK_NEXT(a_data_held, m_tvalid_o && !m_tready_i, $stable(m_tdata_o) && $stable(m_tuser_o))

  // fields that do not belong to the result kind read as zero
  `PCAPDF_CHECK_NOW(a_invalid_clean, m_tvalid_o && m_tuser_o == pcapdf_pkg::KIND_INVALID, m_tdata_o == '0)
  `PCAPDF_CHECK_NOW(a_header_clean, m_tvalid_o && m_tuser_o == pcapdf_pkg::KIND_HEADER, m_tdata_o[pcapdf_pkg::TDATA_W-1:pcapdf_pkg::HDR_W] == '0)
  `PCAPDF_CHECK_NOW(a_record_clean, m_tvalid_o && m_tuser_o == pcapdf_pkg::KIND_RECORD, m_tdata_o[pcapdf_pkg::HDR_W-1:0] == '0)

endmodule

bind pcap_record_deframer_top pcapdf_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o)
);
